// File: rtl/stlb_pkg.sv
// Shared types and constants for the sorted table lower-bound unit.
// Used by stlb_engine and sorted_table_lower_bound_unit; depends on nothing.
package stlb_pkg;

    // Fixed field widths of the block's channels
    localparam int COUNT_W  = 9;
    localparam int POS_W    = 9;
    localparam int IDX_W    = 8;
    localparam int KEY_IN_W = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;

    // Item mode codes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_SIGNED = 1'b1;

    // Search sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } t_state;

    // Lookup request from the top level to the engine
    typedef struct packed {
        logic                start;
        logic [KEY_IN_W-1:0] key;
        logic [COUNT_W-1:0]  count;
        logic                cmp_signed;
    } t_lookup;

    // Finished search result from the engine
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] position;
        logic             exact;
    } t_result;

endpackage

// File: rtl/stlb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependencies.
module stlb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/stlb_engine.sv
// Binary search sequencer: issues one table read per cycle and narrows the range.
// Depends on stlb_pkg; drives the read port of an stlb_ram instance.
module stlb_engine #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  stlb_pkg::t_lookup              i_req,
    input  logic                           i_res_free,
    output logic                           o_idle,
    output stlb_pkg::t_result              o_res,
    output logic                           o_rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_rd_addr,
    input  logic [KEY_WIDTH-1:0]           i_rd_data
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [KEY_WIDTH-1:0] SIGN_MASK = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

    stlb_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]     r_first, n_first;
    logic [CNT_W-1:0]     r_rem, n_rem;
    logic [CNT_W-1:0]     r_mid, n_mid;
    logic [KEY_WIDTH-1:0] r_key;
    logic                 r_exact;

    logic [CNT_W-1:0]     rem0;
    logic [CNT_W-1:0]     half;
    logic [KEY_WIDTH-1:0] key_in;
    logic [KEY_WIDTH-1:0] entry;
    logic                 key_le;
    logic                 key_eq;

    // Range length at start: entry_count saturated to the table depth
    always_comb begin
        if (32'(i_req.count) > 32'(TABLE_DEPTH)) begin
            rem0 = CNT_W'(TABLE_DEPTH);
        end else begin
            rem0 = CNT_W'(i_req.count);
        end
    end

    // Keys mapped so an unsigned compare gives the selected order
    assign key_in = KEY_WIDTH'(i_req.key) ^ (i_req.cmp_signed ? SIGN_MASK : '0);
    assign entry  = i_rd_data ^ (i_req.cmp_signed ? SIGN_MASK : '0);
    assign key_le = (r_key <= entry);
    assign key_eq = (r_key == entry);

    // Range update from the probed entry; next probe address follows directly
    assign half = r_rem >> 1;
    always_comb begin
        if (key_le) begin
            n_first = r_first;
            n_rem   = half;
        end else begin
            n_first = r_mid + CNT_W'(1);
            n_rem   = r_rem - half - CNT_W'(1);
        end
        n_mid = n_first + (n_rem >> 1);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            stlb_pkg::ST_IDLE: begin
                if (i_req.start) begin
                    n_state = (rem0 == '0) ? stlb_pkg::ST_DONE : stlb_pkg::ST_PROBE;
                end
            end
            stlb_pkg::ST_PROBE: begin
                if (n_rem == '0) begin
                    n_state = stlb_pkg::ST_DONE;
                end
            end
            stlb_pkg::ST_DONE: begin
                if (i_res_free) begin
                    n_state = stlb_pkg::ST_IDLE;
                end
            end
            default: n_state = stlb_pkg::ST_IDLE;
        endcase
    end

    // Idle flag depends on the state register only
    assign o_idle = (r_state == stlb_pkg::ST_IDLE);

    // Outputs: read port and result
    always_comb begin
        o_rd_en      = 1'b0;
        o_rd_addr    = '0;
        o_res.valid  = 1'b0;
        o_res.position = stlb_pkg::POS_W'(r_first);
        o_res.exact  = r_exact;
        case (r_state)
            stlb_pkg::ST_IDLE: begin
                o_rd_en   = i_req.start && (rem0 != '0);
                o_rd_addr = AW'(rem0 >> 1);
            end
            stlb_pkg::ST_PROBE: begin
                o_rd_en   = (n_rem != '0);
                o_rd_addr = AW'(n_mid);
            end
            stlb_pkg::ST_DONE: begin
                o_res.valid = 1'b1;
            end
            default: begin
                o_rd_en = 1'b0;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stlb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Search datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            stlb_pkg::ST_IDLE: begin
                if (i_req.start) begin
                    r_first <= '0;
                    r_rem   <= rem0;
                    r_mid   <= rem0 >> 1;
                    r_key   <= key_in;
                    r_exact <= 1'b0;
                end
            end
            stlb_pkg::ST_PROBE: begin
                r_first <= n_first;
                r_rem   <= n_rem;
                r_mid   <= n_mid;
                if (key_eq) begin
                    r_exact <= 1'b1;
                end
            end
            default: begin
                r_first <= r_first;
            end
        endcase
    end

endmodule

// File: rtl/sorted_table_lower_bound_unit.sv
// Top level of the sorted table lower-bound unit: config registers, table
// write path, output register. Depends on stlb_pkg, stlb_ram, stlb_engine.

// A write item (mode 0) stores key_value at entry_index and returns
// nothing; indexes at or beyond TABLE_DEPTH are dropped. A lookup (mode 1)
// runs a binary search over the first entry_count entries: the item is
// taken, then one table read per cycle, at most P probes with
// P = floor(log2(n)) + 1 for n searched entries (zero when n is 0, at most
// 9 for 256), then the result moves into the output register once it is
// free. The rate is set by the single read port of the table memory, whose
// next address is formed from the current compare. A new item is taken
// while the previous result waits on the output side. Configuration writes
// are registered and must be issued only while no lookup is in flight.
module sorted_table_lower_bound_unit #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [stlb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [stlb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input item channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic [stlb_pkg::IDX_W-1:0]          i_entry_index,
    input  logic [stlb_pkg::KEY_IN_W-1:0]       i_key_value,
    // Result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [stlb_pkg::POS_W-1:0]          o_position,
    output logic                                o_key_found
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [stlb_pkg::COUNT_W-1:0] r_entry_count;
    logic                         r_compare_signed;

    logic                         r_out_valid;
    logic [stlb_pkg::POS_W-1:0]   r_position;
    logic                         r_exact;

    logic                         in_xfer;
    logic                         wr_en;
    logic                         eng_idle;
    logic                         res_free;
    stlb_pkg::t_lookup            req;
    stlb_pkg::t_result            res;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [KEY_WIDTH-1:0]         rd_data;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count    <= '0;
            r_compare_signed <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                stlb_pkg::REG_ENTRY_COUNT:    r_entry_count    <= i_cfg_data;
                stlb_pkg::REG_COMPARE_SIGNED: r_compare_signed <= i_cfg_data[0];
                default:                      r_entry_count    <= r_entry_count;
            endcase
        end
    end

    // Input transfer: taken whenever the search engine is idle
    assign o_in_ready = eng_idle;
    assign in_xfer    = i_in_valid && eng_idle;
    assign wr_en      = in_xfer && (i_mode == stlb_pkg::MODE_WRITE)
                        && (32'(i_entry_index) < 32'(TABLE_DEPTH));

    assign req.start      = in_xfer && (i_mode == stlb_pkg::MODE_LOOKUP);
    assign req.key        = i_key_value;
    assign req.count      = r_entry_count;
    assign req.cmp_signed = r_compare_signed;

    // Table memory
    stlb_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_entry_index)),
        .i_wr_data (KEY_WIDTH'(i_key_value)),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Search sequencer
    stlb_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .i_res_free (res_free),
        .o_idle     (eng_idle),
        .o_res      (res),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    // Output register: free when empty or being transferred out
    assign res_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && res_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_free) begin
            r_position <= res.position;
            r_exact    <= res.exact;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_position;
    assign o_key_found = r_exact;

endmodule
